// ===== rtl/core/ddenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddenc_pkg
// Shared constants for the double delta encoder: field layout of a double,
// register indexes and result class codes.
// ----------------------------------------------------------------------------
package ddenc_pkg;

    // double field layout
    localparam int FRAC_W   = 52;
    localparam int EXP_W    = 11;
    localparam int MAG_W    = 63;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
    localparam logic [EXP_W-1:0] EXP_MAX  = 11'd2047;
    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRP_EN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRP_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLT_EN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR     = 2'd3;

    // result classes
    typedef logic [1:0] t_class;
    localparam t_class CLS_EQUAL  = 2'd0;
    localparam t_class CLS_MZERO  = 2'd1;
    localparam t_class CLS_FILTER = 2'd2;
    localparam t_class CLS_CODED  = 2'd3;

endpackage

// ===== rtl/core/double_delta_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_delta_encoder
// Five-stage pipeline: classify and order operands, align and add,
// normalize, round and filter, then build the delta code.
// Throughput: one pair per cycle; a stalled output holds each stage in place.
// Reset: synchronous, active low; clears all valid bits and the configuration
// registers.
// ----------------------------------------------------------------------------
module double_delta_encoder
    import ddenc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [62:0]   i_cfg_wdata,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // [63:0] subtrahend_bits, [127:64] minuend_bits
    // output stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,   // [63:0] delta_code
    output logic [1:0]    o_m_axis_tuser    // [1:0] delta_class
);

    // configuration registers
    logic              r_grp_en;
    logic [11:0]       r_grp_exp;
    logic              r_flt_en;
    logic [MAG_W-1:0]  r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_en  <= 1'b0;
            r_grp_exp <= 12'd0;
            r_flt_en  <= 1'b0;
            r_thr     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRP_EN:  r_grp_en  <= i_cfg_wdata[0];
                CFG_GRP_EXP: r_grp_exp <= i_cfg_wdata[11:0];
                CFG_FLT_EN:  r_flt_en  <= i_cfg_wdata[0];
                CFG_THR:     r_thr     <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // pipeline flow control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || i_m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: classify, handle specials, order operands by magnitude
    // ------------------------------------------------------------------
    logic [63:0]       s_in, m_in;
    logic              a_sgn, b_sgn, a_nan, b_nan, a_inf, b_inf, swap;
    logic [EXP_W-1:0]  a_exp, b_exp, x_exp, y_exp, xe_eff, ye_eff;
    logic [MAG_W-1:0]  a_mag, b_mag, x_mag, y_mag;
    logic [63:0]       n_spec_bits;

    assign s_in  = i_s_axis_tdata[63:0];
    assign m_in  = i_s_axis_tdata[127:64];
    assign a_sgn = m_in[63];
    assign b_sgn = ~s_in[63];
    assign a_mag = m_in[62:0];
    assign b_mag = s_in[62:0];
    assign a_exp = m_in[62:52];
    assign b_exp = s_in[62:52];
    assign a_nan = (a_exp == EXP_MAX) && (|m_in[51:0]);
    assign b_nan = (b_exp == EXP_MAX) && (|s_in[51:0]);
    assign a_inf = (a_exp == EXP_MAX) && !(|m_in[51:0]);
    assign b_inf = (b_exp == EXP_MAX) && !(|s_in[51:0]);
    assign swap  = b_mag > a_mag;
    assign x_mag = swap ? b_mag : a_mag;
    assign y_mag = swap ? a_mag : b_mag;
    assign x_exp = x_mag[62:52];
    assign y_exp = y_mag[62:52];
    assign xe_eff = (x_exp == '0) ? 11'd1 : x_exp;
    assign ye_eff = (y_exp == '0) ? 11'd1 : y_exp;

    // result of non-finite operands
    always_comb begin
        n_spec_bits = CANON_NAN;
        if (a_nan || b_nan)           n_spec_bits = CANON_NAN;
        else if (a_inf && b_inf)      n_spec_bits = (a_sgn != b_sgn) ? CANON_NAN
                                                  : {a_sgn, EXP_MAX, 52'd0};
        else if (a_inf)               n_spec_bits = {a_sgn, EXP_MAX, 52'd0};
        else if (b_inf)               n_spec_bits = {b_sgn, EXP_MAX, 52'd0};
    end

    logic              r1_eq, r1_mz, r1_spec, r1_sgn, r1_sub;
    logic [63:0]       r1_spec_bits;
    logic [EXP_W-1:0]  r1_ex, r1_dsh, r1_mexp;
    logic [52:0]       r1_mx, r1_my;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_eq        <= !a_nan && !b_nan && ((s_in == m_in) ||
                            ((a_mag == '0) && (b_mag == '0)));
            r1_mz        <= (a_mag == '0);
            r1_spec      <= (a_exp == EXP_MAX) || (b_exp == EXP_MAX);
            r1_spec_bits <= n_spec_bits;
            r1_sgn       <= swap ? b_sgn : a_sgn;
            r1_sub       <= a_sgn ^ b_sgn;
            r1_ex        <= xe_eff;
            r1_dsh       <= xe_eff - ye_eff;
            r1_mexp      <= a_exp;
            r1_mx        <= {(x_exp != '0), x_mag[51:0]};
            r1_my        <= {(y_exp != '0), y_mag[51:0]};
        end
    end

    // ------------------------------------------------------------------
    // stage 2: align smaller operand with sticky, add or subtract
    // ------------------------------------------------------------------
    logic [55:0] y56, y_shr, y_mask, y_al;
    logic        y_big, y_sticky;
    logic [56:0] x57, y57;

    assign y56      = {r1_my, 3'b000};
    assign y_big    = r1_dsh >= 11'd56;
    assign y_shr    = y56 >> r1_dsh[5:0];
    assign y_mask   = (56'd1 << r1_dsh[5:0]) - 56'd1;
    assign y_sticky = |(y56 & y_mask);
    assign y_al     = y_big ? {55'd0, |r1_my} : {y_shr[55:1], y_shr[0] | y_sticky};
    assign x57      = {1'b0, r1_mx, 3'b000};
    assign y57      = {1'b0, y_al};

    logic              r2_eq, r2_mz, r2_spec, r2_sgn;
    logic [63:0]       r2_spec_bits;
    logic [EXP_W-1:0]  r2_ex, r2_mexp;
    logic [56:0]       r2_sum;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_eq        <= r1_eq;
            r2_mz        <= r1_mz;
            r2_spec      <= r1_spec;
            r2_spec_bits <= r1_spec_bits;
            r2_sgn       <= r1_sgn;
            r2_ex        <= r1_ex;
            r2_mexp      <= r1_mexp;
            r2_sum       <= r1_sub ? (x57 - y57) : (x57 + y57);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: leading zero count and normalizing shift
    // ------------------------------------------------------------------
    logic [5:0]        lz, nsh;
    logic [EXP_W-1:0]  emax;
    logic [55:0]       norm_l, n_norm;
    logic [11:0]       n_exp;

    always_comb begin
        lz = 6'd55;
        for (int i = 0; i < 56; i++) begin
            if (r2_sum[i]) lz = 6'(55 - i);
        end
    end

    assign emax   = r2_ex - 11'd1;
    assign nsh    = (emax < {5'd0, lz}) ? emax[5:0] : lz;
    assign norm_l = r2_sum[55:0] << nsh;

    always_comb begin
        if (r2_sum[56]) begin
            n_norm = {r2_sum[56:2], r2_sum[1] | r2_sum[0]};
            n_exp  = {1'b0, r2_ex} + 12'd1;
        end else begin
            n_norm = norm_l;
            n_exp  = norm_l[55] ? {1'b0, r2_ex - {5'd0, nsh}} : 12'd0;
        end
    end

    logic              r3_eq, r3_mz, r3_spec, r3_sgn;
    logic [63:0]       r3_spec_bits;
    logic [EXP_W-1:0]  r3_mexp;
    logic [55:0]       r3_norm;
    logic [11:0]       r3_exp;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_eq        <= r2_eq;
            r3_mz        <= r2_mz;
            r3_spec      <= r2_spec;
            r3_spec_bits <= r2_spec_bits;
            r3_sgn       <= r2_sgn;
            r3_mexp      <= r2_mexp;
            r3_norm      <= n_norm;
            r3_exp       <= n_exp;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round to nearest even, threshold filter, class
    // ------------------------------------------------------------------
    logic              rnd_inc, d_nan, t_nan, filt;
    logic [MAG_W-1:0]  rnd_mag;
    logic [63:0]       d_bits;
    t_class            n_class;

    assign rnd_inc = r3_norm[2] & (r3_norm[1] | r3_norm[0] | r3_norm[3]);
    assign rnd_mag = {r3_exp[10:0], r3_norm[54:3]} + {62'd0, rnd_inc};

    always_comb begin
        if (r3_spec)                 d_bits = r3_spec_bits;
        else if (r3_exp >= 12'd2047) d_bits = {r3_sgn, EXP_MAX, 52'd0};
        else                         d_bits = {r3_sgn, rnd_mag};
    end

    assign d_nan = (d_bits[62:52] == EXP_MAX) && (|d_bits[51:0]);
    assign t_nan = (r_thr[62:52] == EXP_MAX) && (|r_thr[51:0]);
    assign filt  = r_flt_en && !d_nan && !t_nan && (d_bits[62:0] < r_thr);

    always_comb begin
        if (r3_eq)      n_class = CLS_EQUAL;
        else if (r3_mz) n_class = CLS_MZERO;
        else if (filt)  n_class = CLS_FILTER;
        else            n_class = CLS_CODED;
    end

    logic [63:0]       r4_d;
    logic [EXP_W-1:0]  r4_mexp;
    t_class            r4_class;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_d     <= d_bits;
            r4_mexp  <= r3_mexp;
            r4_class <= n_class;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: delta code with shifted fraction and marker bits
    // ------------------------------------------------------------------
    logic [12:0]       e_d, e_m, e_diff, e_abs, e_sh;
    logic              above;
    logic [EXP_W-1:0]  code_exp;
    logic [51:0]       code_frac;
    logic [5:0]        mpos;
    logic [63:0]       n_code;

    assign e_d      = {2'b00, r4_d[62:52]} - {2'b00, EXP_BIAS};
    assign e_m      = r_grp_en ? {r_grp_exp[11], r_grp_exp}
                               : {2'b00, r4_mexp} - {2'b00, EXP_BIAS};
    assign e_diff   = e_d - e_m;
    assign above    = !e_diff[12] && (e_diff != 13'd0);
    assign e_abs    = e_diff[12] ? (13'd0 - e_diff) : e_diff;
    assign e_sh     = e_abs + 13'd2;
    assign mpos     = 6'd53 - e_sh[5:0];
    assign code_exp = r_grp_en ? (r_grp_exp[10:0] + EXP_BIAS) : r4_mexp;

    always_comb begin
        code_frac = (e_sh < 13'd64) ? (r4_d[51:0] >> e_sh[5:0]) : 52'd0;
        if (e_sh <= 13'd53)
            code_frac = code_frac | (52'd1 << mpos);
        if (above && (e_sh <= 13'd52))
            code_frac = code_frac | (52'd1 << (mpos - 6'd1));
    end

    always_comb begin
        case (r4_class)
            CLS_EQUAL:  n_code = 64'd0;
            CLS_MZERO:  n_code = SIGN_BIT;
            CLS_FILTER: n_code = 64'd0;
            CLS_CODED:  n_code = {r4_d[63], code_exp, code_frac};
            default:    n_code = 64'd0;
        endcase
    end

    logic [63:0] r5_code;
    t_class      r5_class;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_code  <= n_code;
            r5_class <= r4_class;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = r5_code;
    assign o_m_axis_tuser  = r5_class;

endmodule

// ===== rtl/core/ddenc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddenc_checker
// Port-level checks for the double delta encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ddenc_checker
    import ddenc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  logic [63:0]   o_m_axis_tdata,
    input  logic [1:0]    o_m_axis_tuser
);

    // equal pairs give positive zero
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CLS_EQUAL) |-> o_m_axis_tdata == 64'd0)
        else $error("equal class with nonzero code");

    // zero minuend gives negative zero
    a_mzero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CLS_MZERO) |-> o_m_axis_tdata == SIGN_BIT)
        else $error("minuend zero class with wrong code");

    // filtered differences give positive zero
    a_filter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CLS_FILTER) |-> o_m_axis_tdata == 64'd0)
        else $error("filtered class with nonzero code");

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind double_delta_encoder ddenc_checker u_ddenc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== dv/double_delta_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_delta_encoder_tb
// Streams pairs of double bit patterns into the encoder under several register
// settings and random idling on both stream sides. Each result is compared
// with a delta code worked out in native double arithmetic.
// ----------------------------------------------------------------------------
module double_delta_encoder_tb;
    import ddenc_pkg::*;

    localparam int LATENCY   = 5;
    localparam int MAX_CYCLE = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [62:0]   i_cfg_wdata;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [127:0]  i_s_axis_tdata;   // [63:0] subtrahend_bits, [127:64] minuend_bits
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [63:0]   o_m_axis_tdata;   // [63:0] delta_code
    logic [1:0]    o_m_axis_tuser;   // [1:0] delta_class

    double_delta_encoder dut (.*);

    typedef struct {
        logic [63:0] code;
        t_class      cls;
    } delta_t;

    // shadow copy of the register file
    logic        grp_en_q;
    logic [11:0] grp_exp_q;
    logic        flt_en_q;
    logic [62:0] thr_q;

    delta_t      pending_deltas[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_pairs;
    int          n_checked;
    int          n_errors;
    int          n_coded;
    int          cycle_cnt;

    // clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("double_delta_encoder_tb: errors");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // expected delta code for one pair under the current registers
    function automatic delta_t encode_pair(logic [63:0] s_bits, logic [63:0] m_bits);
        delta_t      r;
        real         s_val;
        real         m_val;
        real         d_val;
        real         thr;
        logic [63:0] d_bits;
        logic [63:0] frac;
        longint      e_d;
        longint      e_m;
        longint      diff;
        longint      sh;
        longint      pos;
        s_val = $bitstoreal(s_bits);
        m_val = $bitstoreal(m_bits);
        if (s_val == m_val) begin
            r.code = '0;
            r.cls  = CLS_EQUAL;
            return r;
        end
        if (m_val == 0.0) begin
            r.code = SIGN_BIT;
            r.cls  = CLS_MZERO;
            return r;
        end
        d_val = m_val - s_val;
        if (flt_en_q) begin
            thr = $bitstoreal({1'b0, thr_q});
            if ((d_val < thr && d_val >= 0.0) || (d_val > -thr && d_val < 0.0)) begin
                r.code = '0;
                r.cls  = CLS_FILTER;
                return r;
            end
        end
        d_bits = $realtobits(d_val);
        if (d_bits[62:52] == EXP_MAX && d_bits[51:0] != '0)
            d_bits = CANON_NAN;
        e_d = longint'(d_bits[62:52]) - 1023;
        if (grp_en_q)
            e_m = longint'($signed(grp_exp_q));
        else
            e_m = longint'(m_bits[62:52]) - 1023;
        diff = e_d - e_m;
        sh   = (diff > 0 ? diff : -diff) + 2;
        frac = {12'd0, d_bits[51:0]};
        frac = (sh < 64) ? (frac >> sh) : '0;
        pos  = 53 - sh;
        if (pos >= 0)
            frac[pos] = 1'b1;
        if (diff > 0 && pos >= 1)
            frac[pos-1] = 1'b1;
        e_m    = e_m + 1023;
        r.code = {d_bits[63], e_m[10:0], frac[51:0]};
        r.cls  = CLS_CODED;
        return r;
    endfunction

    // scoreboard: check output transfers, predict on input transfers
    always @(posedge i_clk) begin
        delta_t want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_checked <= n_checked + 1;
                if (pending_deltas.size() == 0) begin
                    $error("unexpected result: delta_code %h delta_class %0d",
                           o_m_axis_tdata, o_m_axis_tuser);
                    n_errors++;
                end else begin
                    want = pending_deltas.pop_front();
                    if (o_m_axis_tdata !== want.code) begin
                        $error("delta_code: expected %h, got %h", want.code, o_m_axis_tdata);
                        n_errors++;
                    end
                    if (o_m_axis_tuser !== want.cls) begin
                        $error("delta_class: expected %0d, got %0d", want.cls, o_m_axis_tuser);
                        n_errors++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = encode_pair(i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]);
                if (want.cls == CLS_CODED)
                    n_coded <= n_coded + 1;
                pending_deltas.push_back(want);
            end
        end
    end

    // one transfer on the input stream
    task automatic send_pair(logic [63:0] s_bits, logic [63:0] m_bits);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {m_bits, s_bits};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_pairs++;
    endtask

    // drain: drop valid so the last transfer is queued, then wait for results
    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_deltas.size() == 0);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [62:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GRP_EN:  grp_en_q  = val[0];
            CFG_GRP_EXP: grp_exp_q = val[11:0];
            CFG_FLT_EN:  flt_en_q  = val[0];
            CFG_THR:     thr_q     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic g_en, logic [11:0] g_exp, logic f_en, logic [62:0] thr);
        cfg_write(CFG_GRP_EN, 63'(g_en));
        cfg_write(CFG_GRP_EXP, 63'(g_exp));
        cfg_write(CFG_FLT_EN, 63'(f_en));
        cfg_write(CFG_THR, thr);
    endtask

    // finite random double, biased toward interesting regions
    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v[62:52] = '0;                                   // subnormal
            1: v[62:52] = 11'($urandom_range(1023 + 8, 1023 - 8));
            default: ;
        endcase
        if (v[62:52] == EXP_MAX)
            v[52] = 1'b0;
        return v;
    endfunction

    // random pair, many of them close values so that rounding and shifts get work
    task automatic send_random_pair();
        logic [63:0] s_bits;
        logic [63:0] m_bits;
        s_bits = rand_double();
        case ($urandom_range(9))
            0, 1, 2: m_bits = rand_double();
            3, 4, 5: begin
                m_bits = s_bits ^ (64'({$urandom, $urandom}) >> $urandom_range(63, 12));
                if ($urandom_range(1)) m_bits[63] = ~m_bits[63];
            end
            6: m_bits = ($urandom_range(1)) ? s_bits : (s_bits ^ SIGN_BIT);
            7: m_bits = {1'($urandom_range(1)), 63'd0};
            8: begin
                m_bits = rand_double();
                m_bits[62:52] = 11'($urandom_range(2046, 2000));
                s_bits[62:52] = 11'($urandom_range(40));
            end
            default: begin
                m_bits = s_bits;
                m_bits[51:0] = m_bits[51:0] + 52'($urandom_range(4));
            end
        endcase
        if (m_bits[62:52] == EXP_MAX) m_bits[52] = 1'b0;
        send_pair(s_bits, m_bits);
    endtask

    // equality, zero minuend, overflow, subnormals, large shifts
    task automatic test_special_pairs();
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_pair(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_pair(64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_pair(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_pair(64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
        send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
        send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0003);
        send_pair(64'h800F_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF);
        send_pair(64'h7FEF_FFFF_FFFF_FFFE, 64'h7FEF_FFFF_FFFF_FFFF);
        send_pair(64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
        send_pair(64'h0000_0000_0000_0000, 64'h7FE0_0000_0000_0000);
        send_pair(64'h7FE0_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF & ~64'h0010_0000_0000_0000,
                  64'h3FF8_0000_0000_0000);
        end_burst();
    endtask

    // group exponent at its range ends and beyond
    task automatic test_group_mode();
        logic [11:0] g_vals[4];
        g_vals = '{12'h401, 12'h400, 12'h800, 12'h7FF};
        foreach (g_vals[k]) begin
            set_config(1'b1, g_vals[k], 1'b0, '0);
            send_pair(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
            send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002);
            send_pair(64'hC000_0000_0000_0000, 64'h4340_0000_0000_0000);
            end_burst();
        end
    endtask

    // filter with zero, unit and largest thresholds
    task automatic test_filter();
        logic [62:0] thr_vals[3];
        thr_vals = '{63'd0, 63'h3FF0_0000_0000_0000, 63'h7FEF_FFFF_FFFF_FFFF};
        foreach (thr_vals[k]) begin
            set_config(1'b0, '0, 1'b1, thr_vals[k]);
            send_pair(64'h3FF0_0000_0000_0000, 64'h3FF8_0000_0000_0000);
            send_pair(64'h4000_0000_0000_0000, 64'h3FF0_0000_0000_0000);
            send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002);
            send_pair(64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
            end_burst();
        end
    endtask

    // random pairs under a few random register settings
    task automatic test_random_stream(int n_items);
        logic [11:0] g_exp;
        logic [62:0] thr;
        for (int blk = 0; blk < 4; blk++) begin
            g_exp = 12'($signed($urandom_range(2047)) - 1023);
            thr   = 63'($realtobits(10.0 ** ($itor($urandom_range(40)) - 20.0)));
            set_config(1'($urandom_range(1)), g_exp, 1'($urandom_range(1)), thr);
            repeat (n_items / 4) send_random_pair();
            end_burst();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_GRP_EN;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        grp_en_q  = 1'b0;
        grp_exp_q = '0;
        flt_en_q  = 1'b0;
        thr_q     = '0;
        n_pairs   = 0;
        n_checked = 0;
        n_errors  = 0;
        n_coded   = 0;
        cycle_cnt = 0;
        send_idle_pct = 27;
        recv_idle_pct = 59;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_pairs();
        test_group_mode();
        test_filter();
        test_random_stream(600);
        send_idle_pct = 59;
        recv_idle_pct = 27;
        test_random_stream(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(600);
        set_config(1'b0, '0, 1'b0, '0);
        test_special_pairs();

        $display("sent %0d pairs, checked %0d results (%0d encoded deltas)",
                 n_pairs, n_checked, n_coded);
        $display("covered equal, zero-minuend, filtered and encoded classes, group mode");
        if (n_errors == 0 && pending_deltas.size() == 0)
            $display("double_delta_encoder_tb: clean");
        else
            $display("double_delta_encoder_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ddenc_pkg.sv
rtl/core/double_delta_encoder.sv
rtl/core/ddenc_checker.sv
dv/double_delta_encoder_tb.sv
